// File: rtl/core/eikonal_local_update_2d_core_defines.svh
// Assertion macros for the eikonal point update core
`ifndef EIKONAL_LOCAL_UPDATE_2D_CORE_DEFINES_SVH
`define EIKONAL_LOCAL_UPDATE_2D_CORE_DEFINES_SVH
`ifndef ASSERT_OFF
`define ELU2_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);
`define ELU2_ASSERT_ALWAYS(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) prop) else $error(msg);
`else
`define ELU2_ASSERT(lbl, prop, msg)
`define ELU2_ASSERT_ALWAYS(lbl, prop, msg)
`endif
`endif

// File: rtl/core/elu2_pkg.sv
package elu2_pkg;

  localparam int TIME_W = 32;
  localparam int TF     = 16;
  localparam int SPD_W  = 16;
  localparam int SP_W   = 16;
  localparam int U_W    = TIME_W + 2;
  localparam int CU_W   = U_W + 2;
  localparam int DIFF_W = CU_W;
  localparam int A_W    = 2 * SP_W + 5;
  localparam int P_W    = DIFF_W + SPD_W;
  localparam int SC_W   = A_W + 2 * TF + 2;
  localparam int SQ_W   = (SC_W + 1) / 2;
  localparam int RAD_W  = 2 * SQ_W;
  localparam int HALF_W = SQ_W / 2;
  localparam int PH_W   = SQ_W - HALF_W;
  localparam int T_W    = CU_W + SPD_W;
  localparam int TT_W   = T_W + SP_W;
  localparam int T3_W   = TT_W + SP_W;
  localparam int BASE_W = T3_W + 1;
  localparam int NUM_W  = BASE_W + 1;
  localparam int DEN_W  = A_W + SPD_W;
  localparam int IN_W   = 8 * TIME_W + SPD_W;
  localparam int OUT_W  = 40;
  localparam int QDEPTH = 4;
  localparam int QA_W   = $clog2(QDEPTH);

  localparam logic [TIME_W-1:0] TIME_INF      = '1;
  localparam logic [1:0]        ORDER_SECOND  = 2'd2;
  localparam logic [SP_W-1:0]   SPACING_RESET = 16'd256;

  typedef enum logic [1:0] {
    CODE_EXACT = 2'd0,
    CODE_FIRST = 2'd1,
    CODE_DEGEN = 2'd2
  } code_t;

  typedef enum logic [1:0] {
    REG_ROW_SPACING    = 2'd0,
    REG_COLUMN_SPACING = 2'd1,
    REG_SCHEME_ORDER   = 2'd2
  } cfg_idx_t;

  typedef struct packed {
    logic              empty;
    logic              sec;
    logic [TIME_W-1:0] near;
    logic [U_W-1:0]    u2;
  } axis_t;

  typedef struct packed {
    axis_t            ay;
    axis_t            ax;
    logic [SPD_W-1:0] spd;
    logic             none;
  } item_t;

  typedef struct packed {
    logic [SP_W-1:0] dy;
    logic [SP_W-1:0] dx;
    logic            ord2;
  } cfg_t;

  typedef struct packed {
    logic [TIME_W-1:0] arrival_time;
    code_t             error_code;
  } res_t;

endpackage

// File: rtl/core/elu2_front.sv
module elu2_front import elu2_pkg::*; (
  input  logic [IN_W-1:0] tdata,
  output item_t           item
);

  function automatic axis_t pick(input logic [TIME_W-1:0] na, input logic [TIME_W-1:0] nb,
                                 input logic [TIME_W-1:0] fa, input logic [TIME_W-1:0] fb);
    logic [TIME_W-1:0] n;
    logic [TIME_W-1:0] f;
    axis_t r;
    if (na < nb) begin
      n = na;
      f = fa;
    end else begin
      n = nb;
      f = fb;
    end
    r.empty = (na == TIME_INF) && (nb == TIME_INF);
    r.near  = n;
    r.sec   = !r.empty && (f <= n);
    r.u2    = (U_W'(n) << 2) - U_W'(f);
    return r;
  endfunction

  logic [SPD_W-1:0] spd_raw;

  assign spd_raw = tdata[8*TIME_W +: SPD_W];

  // north far/near, south near/far, west far/near, east near/far
  always_comb begin
    item.ay   = pick(tdata[1*TIME_W +: TIME_W], tdata[2*TIME_W +: TIME_W],
                     tdata[0*TIME_W +: TIME_W], tdata[3*TIME_W +: TIME_W]);
    item.ax   = pick(tdata[5*TIME_W +: TIME_W], tdata[6*TIME_W +: TIME_W],
                     tdata[4*TIME_W +: TIME_W], tdata[7*TIME_W +: TIME_W]);
    item.spd  = (spd_raw == '0) ? SPD_W'(1) : spd_raw;
    item.none = item.ay.empty && item.ax.empty;
  end

endmodule

// File: rtl/core/elu2_queue.sv
module elu2_queue import elu2_pkg::*; (
  input  logic  clk,
  input  logic  rst,
  input  logic  wr,
  input  item_t wdata,
  output logic  full,
  input  logic  rd,
  output item_t rdata,
  output logic  nonempty
);

  item_t           mem [QDEPTH];
  logic [QA_W-1:0] wp;
  logic [QA_W-1:0] rp;
  logic [QA_W:0]   count;

  assign full     = (count == (QA_W+1)'(QDEPTH));
  assign nonempty = (count != '0);
  assign rdata    = mem[rp];

  always_ff @(posedge clk) begin
    if (wr) begin
      mem[wp] <= wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wp    <= '0;
      rp    <= '0;
      count <= '0;
    end else begin
      if (wr) begin
        wp <= wp + QA_W'(1);
      end
      if (rd) begin
        rp <= rp + QA_W'(1);
      end
      count <= count + (QA_W+1)'(wr) - (QA_W+1)'(rd);
    end
  end

endmodule

// File: rtl/core/elu2_back.sv
`include "eikonal_local_update_2d_core_defines.svh"

module elu2_back import elu2_pkg::*; (
  input  logic  clk,
  input  logic  rst,
  input  cfg_t  cfg,
  input  item_t item,
  input  logic  in_valid,
  output logic  in_pop,
  output logic  out_valid,
  input  logic  out_ready,
  output res_t  res
);

  localparam logic [1:0] K_NONE   = 2'd0;
  localparam logic [1:0] K_FIRST  = 2'd2;
  localparam logic [1:0] K_SECOND = 2'd3;

  localparam int S_SQ0 = 9;
  localparam int S_P1  = S_SQ0 + SQ_W + 1;
  localparam int S_DV0 = S_P1 + 3;
  localparam int NST   = S_DV0 + TIME_W + 1;

  typedef struct packed {
    logic [1:0]     k;
    logic [U_W-1:0] u;
  } ku_t;

  typedef struct packed {
    item_t                 it;
    logic [1:0][A_W-1:0]   a;
    logic [1:0][DIFF_W-1:0] diff;
  } st1_t;

  typedef struct packed {
    item_t               it;
    logic [1:0][A_W-1:0] a;
    logic [1:0][P_W-1:0] p;
  } st2_t;

  typedef struct packed {
    item_t                        it;
    logic [1:0][A_W-1:0]          a;
    logic [1:0]                   big;
    logic [1:0][2*PH_W-1:0]       hh;
    logic [1:0][PH_W+HALF_W-1:0]  hl;
    logic [1:0][2*HALF_W-1:0]     ll;
  } st3_t;

  typedef struct packed {
    item_t                 it;
    logic [1:0][A_W-1:0]   a;
    logic [1:0]            big;
    logic [1:0][RAD_W-1:0] e;
  } st4_t;

  typedef struct packed {
    ku_t               ky;
    ku_t               kx;
    logic [A_W-1:0]    a;
    logic [RAD_W-1:0]  rad;
    code_t             code;
    logic              deg;
    logic              inf;
    logic [TIME_W-1:0] m;
    logic [SPD_W-1:0]  spd;
  } st5_t;

  typedef struct packed {
    logic [T_W-1:0]    ty;
    logic [T_W-1:0]    tx;
    logic [DEN_W-1:0]  den;
    logic [RAD_W-1:0]  rad;
    code_t             code;
    logic              deg;
    logic              inf;
    logic [TIME_W-1:0] m;
  } st6_t;

  typedef struct packed {
    logic [TT_W-1:0]   ty;
    logic [TT_W-1:0]   tx;
    logic [DEN_W-1:0]  den;
    logic [RAD_W-1:0]  rad;
    code_t             code;
    logic              deg;
    logic              inf;
    logic [TIME_W-1:0] m;
  } st7_t;

  typedef struct packed {
    logic [T3_W-1:0]   ty;
    logic [T3_W-1:0]   tx;
    logic [DEN_W-1:0]  den;
    logic [RAD_W-1:0]  rad;
    code_t             code;
    logic              deg;
    logic              inf;
    logic [TIME_W-1:0] m;
  } st8_t;

  typedef struct packed {
    logic [RAD_W-1:0]  rem;
    logic [SQ_W-1:0]   root;
    logic [BASE_W-1:0] base;
    logic [DEN_W-1:0]  den;
    code_t             code;
    logic              deg;
    logic              inf;
    logic [TIME_W-1:0] m;
  } sq_t;

  typedef struct packed {
    logic [SQ_W+2*SP_W-1:0] sd;
    logic [BASE_W-1:0]      base;
    logic [DEN_W-1:0]       den;
    code_t                  code;
    logic                   deg;
    logic                   inf;
    logic [TIME_W-1:0]      m;
  } pp_t;

  typedef struct packed {
    logic [NUM_W-1:0]  num;
    logic [NUM_W-1:0]  lim;
    logic [DEN_W-1:0]  den;
    code_t             code;
    logic              deg;
    logic              inf;
    logic [TIME_W-1:0] m;
  } pp3_t;

  typedef struct packed {
    logic [NUM_W-1:0]  rem;
    logic [TIME_W-1:0] q;
    logic [DEN_W-1:0]  den;
    code_t             code;
    logic              deg;
    logic              sat;
    logic              inf;
    logic [TIME_W-1:0] m;
  } dv_t;

  function automatic ku_t axis_ku(input axis_t ax, input logic o);
    ku_t r;
    if (ax.empty) begin
      r.k = K_NONE;
      r.u = '0;
    end else if (o && ax.sec) begin
      r.k = K_SECOND;
      r.u = ax.u2;
    end else begin
      r.k = K_FIRST;
      r.u = {1'b0, ax.near, 1'b0};
    end
    return r;
  endfunction

  function automatic logic [CU_W-1:0] kmul(input logic [1:0] k, input logic [U_W-1:0] u);
    logic [CU_W-1:0] ue;
    logic [CU_W-1:0] r;
    ue = CU_W'(u);
    unique case (k)
      K_FIRST:  r = ue << 1;
      K_SECOND: r = (ue << 1) + ue;
      default:  r = '0;
    endcase
    return r;
  endfunction

  function automatic logic [A_W-1:0] kkw(input logic [1:0] k, input logic [2*SP_W-1:0] w);
    logic [A_W-1:0] we;
    logic [A_W-1:0] r;
    we = A_W'(w);
    unique case (k)
      K_FIRST:  r = we << 2;
      K_SECOND: r = (we << 3) + we;
      default:  r = '0;
    endcase
    return r;
  endfunction

  logic                adv;
  logic [NST-1:0]      vp;
  logic [SP_W-1:0]     dxe;
  logic [SP_W-1:0]     dye;
  logic [2*SP_W-1:0]   wa;
  logic [2*SP_W-1:0]   wb;
  item_t               it0;
  st1_t                s1;
  st2_t                s2;
  st3_t                s3;
  st4_t                s4;
  st5_t                s5;
  st6_t                s6;
  st7_t                s7;
  st8_t                s8;
  sq_t                 sq [SQ_W+1];
  pp_t                 p1;
  pp_t                 p2;
  pp3_t                p3;
  dv_t                 dv [TIME_W+1];
  st1_t                s1_next;
  st5_t                s5_next;
  logic [1:0][RAD_W-1:0] sc;
  logic [1:0]          neg;
  logic [TIME_W:0]     dsum;
  res_t                fin;

  assign adv    = !out_valid || out_ready;
  assign in_pop = adv && in_valid;
  assign dxe    = (cfg.dx == '0) ? SP_W'(1) : cfg.dx;
  assign dye    = (cfg.dy == '0) ? SP_W'(1) : cfg.dy;

  always_ff @(posedge clk) begin
    wa <= (2*SP_W)'(dxe) * (2*SP_W)'(dxe);
    wb <= (2*SP_W)'(dye) * (2*SP_W)'(dye);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      vp <= '0;
    end else if (adv) begin
      vp <= {vp[NST-2:0], in_valid};
    end
  end

  // set 0: configured order, set 1: first order
  always_comb begin
    ku_t ky;
    ku_t kx;
    logic [CU_W-1:0] py;
    logic [CU_W-1:0] px;
    s1_next.it = it0;
    for (int s = 0; s < 2; s++) begin
      ky = axis_ku(it0.ay, (s == 0) ? cfg.ord2 : 1'b0);
      kx = axis_ku(it0.ax, (s == 0) ? cfg.ord2 : 1'b0);
      py = kmul(ky.k, kx.u);
      px = kmul(kx.k, ky.u);
      s1_next.a[s]    = kkw(ky.k, wa) + kkw(kx.k, wb);
      s1_next.diff[s] = (py >= px) ? py - px : px - py;
    end
  end

  always_comb begin
    logic okA;
    logic okB;
    for (int s = 0; s < 2; s++) begin
      sc[s]  = RAD_W'({s4.a[s], {(2*TF+2){1'b0}}});
      neg[s] = s4.big[s] || (sc[s] < s4.e[s]);
    end
    okA = !neg[0];
    okB = cfg.ord2 && !neg[1];
    s5_next.inf = s4.it.none;
    s5_next.m   = (s4.it.ay.near < s4.it.ax.near) ? s4.it.ay.near : s4.it.ax.near;
    s5_next.spd = s4.it.spd;
    priority if (okA) begin
      s5_next.ky   = axis_ku(s4.it.ay, cfg.ord2);
      s5_next.kx   = axis_ku(s4.it.ax, cfg.ord2);
      s5_next.a    = s4.a[0];
      s5_next.rad  = sc[0] - s4.e[0];
      s5_next.code = CODE_EXACT;
      s5_next.deg  = 1'b0;
    end else if (okB) begin
      s5_next.ky   = axis_ku(s4.it.ay, 1'b0);
      s5_next.kx   = axis_ku(s4.it.ax, 1'b0);
      s5_next.a    = s4.a[1];
      s5_next.rad  = sc[1] - s4.e[1];
      s5_next.code = CODE_FIRST;
      s5_next.deg  = 1'b0;
    end else begin
      s5_next.ky   = axis_ku(s4.it.ay, 1'b0);
      s5_next.kx   = axis_ku(s4.it.ax, 1'b0);
      s5_next.a    = s4.a[1];
      s5_next.rad  = '0;
      s5_next.code = CODE_DEGEN;
      s5_next.deg  = 1'b1;
    end
    if (s4.it.none) begin
      s5_next.code = CODE_EXACT;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      it0 <= item;
      s1  <= s1_next;

      s2.it <= s1.it;
      s2.a  <= s1.a;
      for (int s = 0; s < 2; s++) begin
        s2.p[s] <= P_W'(s1.diff[s]) * P_W'(s1.it.spd);
      end

      s3.it <= s2.it;
      s3.a  <= s2.a;
      for (int s = 0; s < 2; s++) begin
        s3.big[s] <= (s2.p[s][P_W-1:SQ_W] != '0);
        s3.hh[s]  <= (2*PH_W)'(s2.p[s][SQ_W-1:HALF_W]) * (2*PH_W)'(s2.p[s][SQ_W-1:HALF_W]);
        s3.hl[s]  <= (PH_W+HALF_W)'(s2.p[s][SQ_W-1:HALF_W])
                     * (PH_W+HALF_W)'(s2.p[s][HALF_W-1:0]);
        s3.ll[s]  <= (2*HALF_W)'(s2.p[s][HALF_W-1:0]) * (2*HALF_W)'(s2.p[s][HALF_W-1:0]);
      end

      s4.it  <= s3.it;
      s4.a   <= s3.a;
      s4.big <= s3.big;
      for (int s = 0; s < 2; s++) begin
        s4.e[s] <= (RAD_W'(s3.hh[s]) << (2*HALF_W)) + (RAD_W'(s3.hl[s]) << (HALF_W+1))
                   + RAD_W'(s3.ll[s]);
      end

      s5 <= s5_next;

      s6.ty   <= T_W'(kmul(s5.ky.k, s5.ky.u)) * T_W'(s5.spd);
      s6.tx   <= T_W'(kmul(s5.kx.k, s5.kx.u)) * T_W'(s5.spd);
      s6.den  <= s5.deg ? DEN_W'(s5.spd) : DEN_W'(s5.a) * DEN_W'(s5.spd);
      s6.rad  <= s5.rad;
      s6.code <= s5.code;
      s6.deg  <= s5.deg;
      s6.inf  <= s5.inf;
      s6.m    <= s5.m;

      s7.ty   <= TT_W'(s6.ty) * TT_W'(dxe);
      s7.tx   <= TT_W'(s6.tx) * TT_W'(dye);
      s7.den  <= s6.den;
      s7.rad  <= s6.rad;
      s7.code <= s6.code;
      s7.deg  <= s6.deg;
      s7.inf  <= s6.inf;
      s7.m    <= s6.m;

      s8.ty   <= T3_W'(s7.ty) * T3_W'(dxe);
      s8.tx   <= T3_W'(s7.tx) * T3_W'(dye);
      s8.den  <= s7.den;
      s8.rad  <= s7.rad;
      s8.code <= s7.code;
      s8.deg  <= s7.deg;
      s8.inf  <= s7.inf;
      s8.m    <= s7.m;

      sq[0].rem  <= s8.rad;
      sq[0].root <= '0;
      sq[0].base <= BASE_W'(s8.ty) + BASE_W'(s8.tx);
      sq[0].den  <= s8.den;
      sq[0].code <= s8.code;
      sq[0].deg  <= s8.deg;
      sq[0].inf  <= s8.inf;
      sq[0].m    <= s8.m;
    end
  end

  // integer square root, one result bit per stage
  for (genvar i = 0; i < SQ_W; i++) begin : g_sq
    localparam int B = SQ_W - 1 - i;
    logic [RAD_W-1:0] trial;
    sq_t              sq_next;
    assign trial = (RAD_W'(sq[i].root) << (B + 1)) | (RAD_W'(1) << (2 * B));
    always_comb begin
      sq_next = sq[i];
      if (sq[i].rem >= trial) begin
        sq_next.rem  = sq[i].rem - trial;
        sq_next.root = sq[i].root | (SQ_W'(1) << B);
      end
    end
    always_ff @(posedge clk) begin
      if (adv) begin
        sq[i+1] <= sq_next;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      p1.sd   <= (SQ_W+2*SP_W)'(sq[SQ_W].root) * (SQ_W+2*SP_W)'(dxe);
      p1.base <= sq[SQ_W].base;
      p1.den  <= sq[SQ_W].den;
      p1.code <= sq[SQ_W].code;
      p1.deg  <= sq[SQ_W].deg;
      p1.inf  <= sq[SQ_W].inf;
      p1.m    <= sq[SQ_W].m;

      p2.sd   <= p1.sd * (SQ_W+2*SP_W)'(dye);
      p2.base <= p1.base;
      p2.den  <= p1.den;
      p2.code <= p1.code;
      p2.deg  <= p1.deg;
      p2.inf  <= p1.inf;
      p2.m    <= p1.m;

      p3.num  <= p2.deg ? NUM_W'(1) << (TF + 8) : NUM_W'(p2.base) + NUM_W'(p2.sd);
      p3.lim  <= (NUM_W'(p2.den) << TIME_W) - NUM_W'(p2.den);
      p3.den  <= p2.den;
      p3.code <= p2.code;
      p3.deg  <= p2.deg;
      p3.inf  <= p2.inf;
      p3.m    <= p2.m;

      dv[0].rem  <= p3.num;
      dv[0].q    <= '0;
      dv[0].den  <= p3.den;
      dv[0].code <= p3.code;
      dv[0].deg  <= p3.deg;
      dv[0].sat  <= !p3.deg && (p3.num >= p3.lim);
      dv[0].inf  <= p3.inf;
      dv[0].m    <= p3.m;
    end
  end

  // restoring divider, one quotient bit per stage
  for (genvar i = 0; i < TIME_W; i++) begin : g_dv
    localparam int B = TIME_W - 1 - i;
    logic [NUM_W-1:0] dsh;
    dv_t              dv_next;
    assign dsh = NUM_W'(dv[i].den) << B;
    always_comb begin
      dv_next = dv[i];
      if (dv[i].rem >= dsh) begin
        dv_next.rem = dv[i].rem - dsh;
        dv_next.q   = dv[i].q | (TIME_W'(1) << B);
      end
    end
    always_ff @(posedge clk) begin
      if (adv) begin
        dv[i+1] <= dv_next;
      end
    end
  end

  always_comb begin
    dsum = {1'b0, dv[TIME_W].m} + {1'b0, dv[TIME_W].q};
    fin.error_code = dv[TIME_W].code;
    if (dv[TIME_W].inf) begin
      fin.arrival_time = TIME_INF;
    end else if (dv[TIME_W].deg) begin
      fin.arrival_time = dsum[TIME_W] ? TIME_INF : dsum[TIME_W-1:0];
    end else begin
      fin.arrival_time = dv[TIME_W].sat ? TIME_INF : dv[TIME_W].q;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (adv) begin
      out_valid <= vp[NST-1];
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      res <= fin;
    end
  end

  `ELU2_ASSERT(a_stall_hold, !adv |=> $stable(vp), "pipeline valids moved during stall")
  `ELU2_ASSERT(a_deg_bound, vp[NST-1] && dv[TIME_W].deg |-> dv[TIME_W].q <= (TIME_W'(1) << (TF + 8)), "degenerate quotient too large")
  `ELU2_ASSERT(a_quot_bound, vp[NST-1] && !dv[TIME_W].deg && !dv[TIME_W].sat |-> dv[TIME_W].q != TIME_INF, "unsaturated quotient reached infinity")
  `ELU2_ASSERT_ALWAYS(a_rst_clear, rst |=> (vp == '0) && !out_valid, "reset left pipeline busy")

endmodule

// File: rtl/core/eikonal_local_update_2d_core.sv
// Second-order fast-marching point update: from the eight frozen neighbor
// times (Q16.16, all ones = infinity) and the local speed it returns the new
// arrival time and a code (exact, first-order fallback, degenerate). One word
// is accepted per clock while the input queue is not full; results pass the
// 36-stage pipelined square root and the 32-stage pipelined divider. A
// 4-word queue after the classifier absorbs output stalls. The user must write
// spacing and order registers only while no word is in flight (not enforced).
module eikonal_local_update_2d_core import elu2_pkg::*; (
  input  logic             clk,
  input  logic             rst,
  input  logic             s_tvalid,
  output logic             s_tready,
  // north_far, north_near, south_near, south_far, west_far, west_near,
  // east_near, east_far (32 each), local_speed (16)
  input  logic [IN_W-1:0]  s_tdata,
  output logic             m_tvalid,
  input  logic             m_tready,
  // arrival_time (32), error_code (2), zero pad
  output logic [OUT_W-1:0] m_tdata,
  input  logic             cfg_valid,
  output logic             cfg_ready,
  input  logic [1:0]       cfg_index,
  input  logic [SP_W-1:0]  cfg_data
);

  logic [SP_W-1:0] row_spacing;
  logic [SP_W-1:0] column_spacing;
  logic [1:0]      scheme_order;
  cfg_t            cfg;
  item_t           item_in;
  item_t           item_q;
  logic            q_full;
  logic            q_nonempty;
  logic            q_pop;
  res_t            res;

  assign cfg_ready = 1'b1;
  assign s_tready  = !q_full;
  assign cfg.dy    = row_spacing;
  assign cfg.dx    = column_spacing;
  assign cfg.ord2  = (scheme_order == ORDER_SECOND);
  assign m_tdata   = {{(OUT_W-TIME_W-2){1'b0}}, res.error_code, res.arrival_time};

  always_ff @(posedge clk) begin
    if (rst) begin
      row_spacing    <= SPACING_RESET;
      column_spacing <= SPACING_RESET;
      scheme_order   <= ORDER_SECOND;
    end else if (cfg_valid && cfg_ready) begin
      unique case (cfg_index)
        REG_ROW_SPACING:    row_spacing    <= cfg_data;
        REG_COLUMN_SPACING: column_spacing <= cfg_data;
        REG_SCHEME_ORDER:   scheme_order   <= cfg_data[1:0];
        default: ;
      endcase
    end
  end

  elu2_front u_front (
    .tdata (s_tdata),
    .item  (item_in)
  );

  elu2_queue u_queue (
    .clk      (clk),
    .rst      (rst),
    .wr       (s_tvalid && s_tready),
    .wdata    (item_in),
    .full     (q_full),
    .rd       (q_pop),
    .rdata    (item_q),
    .nonempty (q_nonempty)
  );

  elu2_back u_back (
    .clk       (clk),
    .rst       (rst),
    .cfg       (cfg),
    .item      (item_q),
    .in_valid  (q_nonempty),
    .in_pop    (q_pop),
    .out_valid (m_tvalid),
    .out_ready (m_tready),
    .res       (res)
  );

endmodule
